// ----- design/glr_pkg.sv -----
// Shared types and constants for the gradient line rasterizer.
// Imported by every module of the block; depends on nothing.

package glr_pkg;

    localparam int COORD_BITS      = 12;
    localparam int CHAN_BITS       = 8;
    localparam int NUM_CHAN        = 3;
    localparam int COLOR_BITS      = CHAN_BITS * NUM_CHAN;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Command codes on the input channel
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] span_t;
    typedef logic signed [COORD_BITS:0]   err_t;
    typedef logic        [CHAN_BITS-1:0]  chan_t;
    typedef logic        [COLOR_BITS-1:0] color_t;

    // One queued command: a line set-up (is_load) or a bare step request
    typedef struct packed {
        logic                      is_load;
        logic                      swap_axes;
        logic                      minor_down;
        coord_t                    start_major;
        coord_t                    start_minor;
        coord_t                    end_major;
        span_t                     major_span;
        span_t                     minor_span;
        chan_t [NUM_CHAN-1:0]      left;
        logic  [NUM_CHAN-1:0]      neg;
        chan_t [NUM_CHAN-1:0]      mag;
    } glr_entry_t;

endpackage

// ----- design/glr_front.sv -----
// Front end: accepts commands, sets up lines and filters steps to idle lines.
// Depends on glr_pkg; feeds glr_queue.

module glr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  glr_pkg::coord_t    s_x_start,
    input  glr_pkg::coord_t    s_y_start,
    input  glr_pkg::coord_t    s_x_end,
    input  glr_pkg::coord_t    s_y_end,
    input  glr_pkg::color_t    s_color_start,
    input  glr_pkg::color_t    s_color_end,
    input  logic               q_full,
    output logic               q_push,
    output glr_pkg::glr_entry_t q_entry
);
    import glr_pkg::*;

    logic                  active_reg, active_next;
    span_t                 remain_reg, remain_next;
    logic                  accept;

    logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
    span_t                 adx, ady;
    logic                  swap, rev;
    logic [COORD_BITS:0]   nd;
    logic                  nd_neg, nd_zero;
    coord_t                a0, a1, b0, b1;
    chan_t [NUM_CHAN-1:0]  c0_arr, c1_arr, lft, rgt;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Axis choice and endpoint ordering
    always_comb begin
        dx     = {s_x_end[COORD_BITS-1], s_x_end} - {s_x_start[COORD_BITS-1], s_x_start};
        dy     = {s_y_end[COORD_BITS-1], s_y_end} - {s_y_start[COORD_BITS-1], s_y_start};
        dx_neg = -dx;
        dy_neg = -dy;
        adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        swap   = ady > adx;
        rev    = swap ? dy[COORD_BITS] : dx[COORD_BITS];
        nd     = swap ? dx : dy;
        nd_neg = nd[COORD_BITS];
        nd_zero = (nd == '0);
        a0     = swap ? s_y_start : s_x_start;
        a1     = swap ? s_y_end   : s_x_end;
        b0     = swap ? s_x_start : s_y_start;
        b1     = swap ? s_x_end   : s_y_end;
        c0_arr = s_color_start;
        c1_arr = s_color_end;
        lft    = rev ? c1_arr : c0_arr;
        rgt    = rev ? c0_arr : c1_arr;

        q_entry             = '0;
        q_entry.is_load     = (s_cmd == CMD_LOAD);
        q_entry.swap_axes   = swap;
        q_entry.minor_down  = rev ? !nd_neg : (nd_neg || nd_zero);
        q_entry.start_major = rev ? a1 : a0;
        q_entry.end_major   = rev ? a0 : a1;
        q_entry.start_minor = rev ? b1 : b0;
        q_entry.major_span  = swap ? ady : adx;
        q_entry.minor_span  = swap ? adx : ady;
        q_entry.left        = lft;
        // Per channel sign and size of the colour difference
        for (int i = 0; i < NUM_CHAN; i++) begin
            q_entry.neg[i] = rgt[i] < lft[i];
            q_entry.mag[i] = (rgt[i] < lft[i]) ? (lft[i] - rgt[i]) : (rgt[i] - lft[i]);
        end
    end

    // Track the line being walked so steps past its end are dropped here
    always_comb begin
        active_next = active_reg;
        remain_next = remain_reg;
        q_push      = 1'b0;
        if (accept) begin
            if (s_cmd == CMD_LOAD) begin
                q_push      = 1'b1;
                active_next = 1'b1;
                remain_next = q_entry.major_span;
            end else if (active_reg) begin
                q_push = 1'b1;
                if (remain_reg == '0) begin
                    active_next = 1'b0;
                end else begin
                    remain_next = remain_reg - span_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            remain_reg <= '0;
        end else begin
            active_reg <= active_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- design/glr_queue.sv -----
// Short command queue between the front and back ends.
// Depends on glr_pkg for the entry type.

module glr_queue #(
    parameter int DEPTH = glr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  glr_pkg::glr_entry_t push_entry,
    input  logic                pop,
    output glr_pkg::glr_entry_t head,
    output logic                head_valid,
    output logic                full
);
    import glr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    glr_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push, do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/glr_div.sv -----
// Restoring divider, one quotient bit per cycle, three colour lanes side by side.
// Gives the per-step colour increment (quotient and remainder of diff / span).

module glr_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  glr_pkg::chan_t [glr_pkg::NUM_CHAN-1:0] dividend,
    input  glr_pkg::span_t                       divisor,
    output logic                                 busy,
    output glr_pkg::chan_t [glr_pkg::NUM_CHAN-1:0] quot,
    output glr_pkg::span_t [glr_pkg::NUM_CHAN-1:0] rem
);
    import glr_pkg::*;

    localparam int CNT_W = $clog2(CHAN_BITS);

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    span_t                  divisor_reg;
    chan_t [NUM_CHAN-1:0]   dvd_reg, dvd_next;
    chan_t [NUM_CHAN-1:0]   quot_reg, quot_next;
    span_t [NUM_CHAN-1:0]   rem_reg, rem_next;
    logic [COORD_BITS:0]    rem_sh [NUM_CHAN];
    logic [COORD_BITS:0]    trial [NUM_CHAN];
    logic [NUM_CHAN-1:0]    ge;

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    // One shift-and-subtract step per lane
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            rem_sh[i]   = {rem_reg[i], dvd_reg[i][CHAN_BITS-1]};
            trial[i]    = rem_sh[i] - {1'b0, divisor_reg};
            ge[i]       = rem_sh[i] >= {1'b0, divisor_reg};
            rem_next[i] = ge[i] ? trial[i][COORD_BITS-1:0] : rem_sh[i][COORD_BITS-1:0];
            quot_next[i] = {quot_reg[i][CHAN_BITS-2:0], ge[i]};
            dvd_next[i] = {dvd_reg[i][CHAN_BITS-2:0], 1'b0};
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg     <= dividend;
            divisor_reg <= divisor;
            quot_reg    <= '0;
            rem_reg     <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    // Iteration count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CHAN_BITS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/glr_back.sv -----
// Back end: walks the line (Bresenham), blends colour incrementally, drives results.
// Depends on glr_pkg and glr_div; pops commands from glr_queue.

module glr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  glr_pkg::glr_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output glr_pkg::coord_t     m_pixel_x,
    output glr_pkg::coord_t     m_pixel_y,
    output glr_pkg::color_t     m_pixel_color,
    output logic                m_last_pixel
);
    import glr_pkg::*;

    typedef enum logic [1:0] {
        ST_WALK = 2'b01,
        ST_DIV  = 2'b10
    } back_state_t;

    back_state_t            state_reg, state_next;

    // Walk state
    logic                   swap_reg, down_reg;
    coord_t                 cur_major_reg, cur_minor_reg, end_major_reg;
    span_t                  major_span_reg, minor_span_reg;
    err_t                   err_reg, err_next, err_sub;
    chan_t [NUM_CHAN-1:0]   left_reg;
    logic  [NUM_CHAN-1:0]   neg_reg;
    chan_t [NUM_CHAN-1:0]   acc_q_reg, acc_q_next;
    span_t [NUM_CHAN-1:0]   acc_r_reg, acc_r_next;
    coord_t                 cur_minor_next;

    // Output stage
    logic                   m_valid_reg;
    coord_t                 pix_x_reg, pix_y_reg;
    color_t                 pix_color_reg;
    logic                   last_reg;

    // Divider
    logic                   div_start, div_busy;
    chan_t [NUM_CHAN-1:0]   q_step;
    span_t [NUM_CHAN-1:0]   r_step;

    logic                   out_free, pop_load, pop_step;
    chan_t [NUM_CHAN-1:0]   color_arr;
    logic [COORD_BITS:0]    r_sum [NUM_CHAN];
    logic [COORD_BITS:0]    r_red [NUM_CHAN];
    logic [NUM_CHAN-1:0]    r_wrap;

    glr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (head.mag),
        .divisor  (head.major_span),
        .busy     (div_busy),
        .quot     (q_step),
        .rem      (r_step)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_load  = (state_reg == ST_WALK) && head_valid && head.is_load;
    assign pop_step  = (state_reg == ST_WALK) && head_valid && !head.is_load && out_free;
    assign pop       = pop_load || pop_step;
    assign div_start = pop_load;

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = pix_x_reg;
    assign m_pixel_y     = pix_y_reg;
    assign m_pixel_color = pix_color_reg;
    assign m_last_pixel  = last_reg;

    // Sequencer: a load waits for the colour step division
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_WALK: if (pop_load) state_next = ST_DIV;
            ST_DIV:  if (!div_busy) state_next = ST_WALK;
            default: state_next = ST_WALK;
        endcase
    end

    // Current colour, and the colour accumulators for the next pixel
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            color_arr[i]  = neg_reg[i] ? (left_reg[i] - acc_q_reg[i])
                                       : (left_reg[i] + acc_q_reg[i]);
            r_sum[i]      = {1'b0, acc_r_reg[i]} + {1'b0, r_step[i]};
            r_red[i]      = r_sum[i] - {1'b0, major_span_reg};
            r_wrap[i]     = r_sum[i] >= {1'b0, major_span_reg};
            acc_r_next[i] = r_wrap[i] ? r_red[i][COORD_BITS-1:0] : r_sum[i][COORD_BITS-1:0];
            acc_q_next[i] = acc_q_reg[i] + q_step[i] + chan_t'(r_wrap[i]);
        end
    end

    // Bresenham error step
    always_comb begin
        err_sub        = err_reg - err_t'({1'b0, minor_span_reg});
        err_next       = err_sub;
        cur_minor_next = cur_minor_reg;
        if (err_sub[COORD_BITS]) begin
            err_next       = err_sub + err_t'({1'b0, major_span_reg});
            cur_minor_next = down_reg ? (cur_minor_reg - coord_t'(1))
                                      : (cur_minor_reg + coord_t'(1));
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        if (pop_load) begin
            swap_reg       <= head.swap_axes;
            down_reg       <= head.minor_down;
            cur_major_reg  <= head.start_major;
            cur_minor_reg  <= head.start_minor;
            end_major_reg  <= head.end_major;
            major_span_reg <= head.major_span;
            minor_span_reg <= head.minor_span;
            err_reg        <= err_t'({2'b00, head.major_span[COORD_BITS-1:1]});
            left_reg       <= head.left;
            neg_reg        <= head.neg;
            acc_q_reg      <= '0;
            acc_r_reg      <= '0;
        end else if (pop_step) begin
            cur_major_reg <= cur_major_reg + coord_t'(1);
            cur_minor_reg <= cur_minor_next;
            err_reg       <= err_next;
            acc_q_reg     <= acc_q_next;
            acc_r_reg     <= acc_r_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop_step) begin
            pix_x_reg     <= swap_reg ? cur_minor_reg : cur_major_reg;
            pix_y_reg     <= swap_reg ? cur_major_reg : cur_minor_reg;
            pix_color_reg <= color_arr;
            last_reg      <= (cur_major_reg == end_major_reg);
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WALK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/gradient_line_rasterizer_core.sv -----
// Top level of the gradient line rasterizer: front end, command queue, back end.
// Depends on glr_pkg, glr_front, glr_queue, glr_div and glr_back.
//
//   Channel   Direction  Handshake          Transfer
//   s_*       in         s_valid / s_ready  one command: load a line or step one pixel
//   m_*       out        m_valid / m_ready  one pixel with blended colour and last flag
//
// Steps give one pixel per cycle unless stalled, registered in queue and output stage.
// A load holds the back end for the restoring divide of the colour step;
//   steps behind it wait in the queue, and s_ready drops only when the queue is full.
// Steps to an idle line are taken and dropped in the front end.
// aresetn is synchronous; it empties the queue and the output stage.
// A stall on m_ready holds the output register and backs up into the queue.

module gradient_line_rasterizer_core #(
    parameter int QUEUE_DEPTH = glr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  glr_pkg::coord_t  s_x_start,
    input  glr_pkg::coord_t  s_y_start,
    input  glr_pkg::coord_t  s_x_end,
    input  glr_pkg::coord_t  s_y_end,
    input  glr_pkg::color_t  s_color_start,
    input  glr_pkg::color_t  s_color_end,
    output logic             m_valid,
    input  logic             m_ready,
    output glr_pkg::coord_t  m_pixel_x,
    output glr_pkg::coord_t  m_pixel_y,
    output glr_pkg::color_t  m_pixel_color,
    output logic             m_last_pixel
);
    import glr_pkg::*;

    glr_entry_t  push_entry, head;
    logic        push, pop, head_valid, full;

    glr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_x_start     (s_x_start),
        .s_y_start     (s_y_start),
        .s_x_end       (s_x_end),
        .s_y_end       (s_y_end),
        .s_color_start (s_color_start),
        .s_color_end   (s_color_end),
        .q_full        (full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    glr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    glr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule

// ----- design/glr_checker.sv -----
// Port-level checks for the gradient line rasterizer, bound to the top level.
// Depends on glr_pkg for the command codes and field types.

module glr_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_cmd,
    input logic             m_valid,
    input logic             m_ready,
    input glr_pkg::coord_t  m_pixel_x,
    input glr_pkg::coord_t  m_pixel_y,
    input glr_pkg::color_t  m_pixel_color,
    input logic             m_last_pixel
);
    import glr_pkg::*;

    logic [31:0] step_cnt_reg, step_cnt_next;
    logic [31:0] pix_cnt_reg, pix_cnt_next;

    // Running totals of step transfers in and pixel transfers out
    always_comb begin
        step_cnt_next = step_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        if (s_valid && s_ready && (s_cmd == CMD_STEP)) begin
            step_cnt_next = step_cnt_reg + 32'd1;
        end
        if (m_valid && m_ready) begin
            pix_cnt_next = pix_cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
            pix_cnt_reg  <= '0;
        end else begin
            step_cnt_reg <= step_cnt_next;
            pix_cnt_reg  <= pix_cnt_next;
        end
    end

    // Reset empties the output stage
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every pixel answers an earlier step transfer
    a_pixel_has_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |-> (pix_cnt_reg < step_cnt_reg))
        else $error("pixel without a step request");

    // A stalled pixel holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
                                   && $stable(m_pixel_color) && $stable(m_last_pixel)))
        else $error("stalled pixel changed");

endmodule

bind gradient_line_rasterizer_core glr_checker u_glr_checker (.*);
